// ----- src/cia_pkg.sv -----
// ----------------------------------------------------------------------------
// cia_pkg
// Operation codes shared by the complex integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

	// operation selector carried in the request tuser
	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_SWAP = 3'd4
	} kind_t;

	localparam int unsigned KIND_W = 3;
	localparam int unsigned FIELD_W = 32;

endpackage

// ----- src/complex_integer_alu.sv -----
// ----------------------------------------------------------------------------
// complex_integer_alu
// Pipelined Gaussian-integer unit: add, subtract, multiply, divide, swap.
// Stages: operand capture, products, dot products and divisor, divider entry,
// a 2*DATA_WIDTH-stage restoring divider, and an output register.
// Throughput: one request per cycle; a stall on m_axis holds every stage.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module complex_integer_alu
	import cia_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// a_real [31:0], a_imag [63:32], b_real [95:64], b_imag [127:96]
	input  logic [4*FIELD_W-1:0] s_axis_tdata,
	// kind [2:0]
	input  logic [KIND_W-1:0]    s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// result_real [31:0], result_imag [63:32]
	output logic [2*FIELD_W-1:0] m_axis_tdata,
	// divide_by_zero [0]
	output logic                 m_axis_tuser
);

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned PW = 2 * DATA_WIDTH;   // product / quotient width
	localparam int unsigned ST = 2 * DATA_WIDTH;   // divider stages

	// global advance: the whole pipe moves unless the output is held
	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: operand capture ----------------
	logic                v_s1;
	kind_t               kind_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_t'(s_axis_tuser);
			ar_s1   <= s_axis_tdata[W-1:0];
			ai_s1   <= s_axis_tdata[FIELD_W +: W];
			br_s1   <= s_axis_tdata[2*FIELD_W +: W];
			bi_s1   <= s_axis_tdata[3*FIELD_W +: W];
		end
	end

	// ---------------- stage 2: products and simple ops ----------------
	logic                 v_s2, dz_s2;
	kind_t                kind_s2;
	logic [W-1:0]         sre_s2, sim_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, q_r_s2, q_i_s2;
	logic [W-1:0]         sre_c, sim_c;

	// add, subtract and swap need no products
	always_comb begin
		sre_c = '0;
		sim_c = '0;
		case (kind_s1)
			KIND_ADD: begin
				sre_c = ar_s1 + br_s1;
				sim_c = ai_s1 + bi_s1;
			end
			KIND_SUB: begin
				sre_c = ar_s1 - br_s1;
				sim_c = ai_s1 - bi_s1;
			end
			KIND_SWAP: begin
				sre_c = ai_s1;
				sim_c = ar_s1;
			end
			default: begin
				sre_c = '0;
				sim_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			dz_s2   <= (kind_s1 == KIND_DIV) && (br_s1 == '0) && (bi_s1 == '0);
			sre_s2  <= sre_c;
			sim_s2  <= sim_c;
			p_rr_s2 <= ar_s1 * br_s1;
			p_ii_s2 <= ai_s1 * bi_s1;
			p_ri_s2 <= ar_s1 * bi_s1;
			p_ir_s2 <= ai_s1 * br_s1;
			q_r_s2  <= br_s1 * br_s1;
			q_i_s2  <= bi_s1 * bi_s1;
		end
	end

	// ---------------- stage 3: dot products and divisor ----------------
	logic                 v_s3, dz_s3;
	kind_t                kind_s3;
	logic [W-1:0]         sre_s3, sim_s3;
	logic signed [PW:0]   dre_s3, dim_s3;
	logic [PW-1:0]        den_s3;
	logic [PW-1:0]        mre_c, mim_c;

	assign mre_c = p_rr_s2 - p_ii_s2;
	assign mim_c = p_ri_s2 + p_ir_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_s2;
			dz_s3   <= dz_s2;
			sre_s3  <= (kind_s2 == KIND_MUL) ? mre_c[W-1:0] : sre_s2;
			sim_s3  <= (kind_s2 == KIND_MUL) ? mim_c[W-1:0] : sim_s2;
			dre_s3  <= (PW+1)'(p_rr_s2) + (PW+1)'(p_ii_s2);
			dim_s3  <= (PW+1)'(p_ir_s2) - (PW+1)'(p_ri_s2);
			den_s3  <= $unsigned(q_r_s2) + $unsigned(q_i_s2);
		end
	end

	// ---------------- stage 4: sign and magnitude, divider entry ----------------
	logic [PW:0] nre_c, nim_c;
	assign nre_c = -dre_s3;
	assign nim_c = -dim_s3;

	// per-stage divider state, index 0 is the entry register
	logic          dv_s   [0:ST];
	logic          ddz_s  [0:ST];
	kind_t         dkind_s[0:ST];
	logic [W-1:0]  dsre_s [0:ST];
	logic [W-1:0]  dsim_s [0:ST];
	logic          dnre_s [0:ST];
	logic          dnim_s [0:ST];
	logic [PW-1:0] dden_s [0:ST];
	logic [PW-1:0] rre_s  [0:ST];
	logic [PW-1:0] rim_s  [0:ST];
	logic [PW-1:0] qre_s  [0:ST];
	logic [PW-1:0] qim_s  [0:ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else if (en) dv_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ddz_s[0]   <= dz_s3;
			dkind_s[0] <= kind_s3;
			dsre_s[0]  <= sre_s3;
			dsim_s[0]  <= sim_s3;
			dnre_s[0]  <= dre_s3[PW];
			dnim_s[0]  <= dim_s3[PW];
			dden_s[0]  <= den_s3;
			rre_s[0]   <= '0;
			rim_s[0]   <= '0;
			qre_s[0]   <= dre_s3[PW] ? nre_c[PW-1:0] : dre_s3[PW-1:0];
			qim_s[0]   <= dim_s3[PW] ? nim_c[PW-1:0] : dim_s3[PW-1:0];
		end
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	for (genvar g = 0; g < ST; g++) begin : g_div
		logic [PW:0] sh_re, sh_im, tr_re, tr_im;

		assign sh_re = {rre_s[g], qre_s[g][PW-1]};
		assign sh_im = {rim_s[g], qim_s[g][PW-1]};
		assign tr_re = sh_re - {1'b0, dden_s[g]};
		assign tr_im = sh_im - {1'b0, dden_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[g+1] <= 1'b0;
			else if (en) dv_s[g+1] <= dv_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ddz_s[g+1]   <= ddz_s[g];
				dkind_s[g+1] <= dkind_s[g];
				dsre_s[g+1]  <= dsre_s[g];
				dsim_s[g+1]  <= dsim_s[g];
				dnre_s[g+1]  <= dnre_s[g];
				dnim_s[g+1]  <= dnim_s[g];
				dden_s[g+1]  <= dden_s[g];
				rre_s[g+1]   <= tr_re[PW] ? sh_re[PW-1:0] : tr_re[PW-1:0];
				rim_s[g+1]   <= tr_im[PW] ? sh_im[PW-1:0] : tr_im[PW-1:0];
				qre_s[g+1]   <= {qre_s[g][PW-2:0], !tr_re[PW]};
				qim_s[g+1]   <= {qim_s[g][PW-2:0], !tr_im[PW]};
			end
		end
	end

	// ---------------- output register ----------------
	logic [W-1:0]        qre_w, qim_w;
	logic signed [W-1:0] ore_c, oim_c;
	logic signed [W-1:0] ore_q, oim_q;
	logic                odz_q;

	assign qre_w = qre_s[ST][W-1:0];
	assign qim_w = qim_s[ST][W-1:0];

	// apply quotient sign; zero divisor gives zero parts
	always_comb begin
		ore_c = dsre_s[ST];
		oim_c = dsim_s[ST];
		if (dkind_s[ST] == KIND_DIV) begin
			if (ddz_s[ST]) begin
				ore_c = '0;
				oim_c = '0;
			end else begin
				ore_c = dnre_s[ST] ? -qre_w : qre_w;
				oim_c = dnim_s[ST] ? -qim_w : qim_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= dv_s[ST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ore_q <= ore_c;
			oim_q <= oim_c;
			odz_q <= ddz_s[ST];
		end
	end

	assign m_axis_tdata = {FIELD_W'(oim_q), FIELD_W'(ore_q)};
	assign m_axis_tuser = odz_q;

endmodule
